// File: rtl/core/mwem_pkg.sv
package mwem_pkg;

    // Default widths of the serial frame.
    localparam int unsigned DATA_BITS_DEF  = 16;
    localparam int unsigned INSTR_BITS_DEF = 8;

    // Command codes carried by an item.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_READ    = 3'd2;
    localparam logic [2:0] ACT_ENABLE  = 3'd3;
    localparam logic [2:0] ACT_DISABLE = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_HALF_PERIOD  = 3'd0;
    localparam logic [2:0] REG_SAMPLE_DELAY = 3'd1;
    localparam logic [2:0] REG_WRITE_WAIT   = 3'd2;
    localparam logic [2:0] REG_POLL_READY   = 3'd3;
    localparam logic [2:0] REG_READ_OPCODE  = 3'd4;
    localparam logic [2:0] REG_EN_OPCODE    = 3'd5;
    localparam logic [2:0] REG_DIS_OPCODE   = 3'd6;

    // Configuration reset values.
    localparam logic [7:0]  HALF_PERIOD_RST  = 8'd1;
    localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd1;
    localparam logic [15:0] WRITE_WAIT_RST   = 16'd5000;
    localparam logic        POLL_READY_RST   = 1'b0;
    localparam logic [7:0]  READ_OPCODE_RST  = 8'd128;
    localparam logic [7:0]  EN_OPCODE_RST    = 8'd48;
    localparam logic [7:0]  DIS_OPCODE_RST   = 8'd0;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_SETUP     = 4'd1;
    localparam logic [3:0] PH_SEND_LOW  = 4'd2;
    localparam logic [3:0] PH_SEND_HIGH = 4'd3;
    localparam logic [3:0] PH_RECV_LOW  = 4'd4;
    localparam logic [3:0] PH_RECV_HIGH = 4'd5;
    localparam logic [3:0] PH_HOLD      = 4'd6;
    localparam logic [3:0] PH_WAIT      = 4'd7;
    localparam logic [3:0] PH_POLL      = 4'd8;

endpackage

// File: rtl/core/microwire_eeprom_master_core.sv
// Microwire master for a word-organized serial EEPROM. Every accepted item is
// one base time tick and yields exactly one result item holding the pin
// levels for that tick (chip select, serial clock, serial data out), the busy
// flag, the receive word and a read-complete strobe. An item with a command
// code is taken only while idle; otherwise it is a plain tick. A command
// raises chip select for one setup tick, shifts a start bit plus an
// INSTR_BITS instruction MSB first (and DATA_BITS data bits for a write), then
// for a read clocks in DATA_BITS bits, sampling serial_in sample_delay_ticks
// after the rising clock edge. A hold tick with chip select low follows; a
// write then waits write_wait_ticks ticks or polls serial_in for ready.
// Rate: one item per clock cycle while the skid register is empty. The tick
// sequencer updates once per accepted item; results land in a two-entry output
// buffer (output register plus skid register), so s_ready depends only on the
// skid register and the input keeps moving while one result waits at the
// output. Configuration writes through cfg_we/cfg_index/cfg_wdata take effect
// on the next edge; write them only while the block is idle.
module microwire_eeprom_master_core #(
    parameter int unsigned DATA_BITS  = mwem_pkg::DATA_BITS_DEF,
    parameter int unsigned INSTR_BITS = mwem_pkg::INSTR_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,

    // tick items in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_action,
    input  logic [7:0]           s_address,
    input  logic [7:0]           s_write_opcode,
    input  logic [DATA_BITS-1:0] s_write_data,
    input  logic                 s_serial_in,

    // pin-level items out
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_chip_select,
    output logic                 m_serial_clock,
    output logic                 m_serial_out,
    output logic                 m_busy_res,
    output logic [DATA_BITS-1:0] m_read_word,
    output logic                 m_read_done
);

    localparam int unsigned SEND_W = 1 + INSTR_BITS + DATA_BITS;
    localparam int unsigned BCNT_W = $clog2(SEND_W + 1);
    localparam int unsigned BIDX_W = $clog2(SEND_W);
    localparam int unsigned RES_W  = 5 + DATA_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  half_period_reg;
    logic [7:0]  sample_delay_reg;
    logic [15:0] write_wait_reg;
    logic        poll_ready_reg;
    logic [7:0]  read_opcode_reg;
    logic [7:0]  en_opcode_reg;
    logic [7:0]  dis_opcode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg  <= mwem_pkg::HALF_PERIOD_RST;
            sample_delay_reg <= mwem_pkg::SAMPLE_DELAY_RST;
            write_wait_reg   <= mwem_pkg::WRITE_WAIT_RST;
            poll_ready_reg   <= mwem_pkg::POLL_READY_RST;
            read_opcode_reg  <= mwem_pkg::READ_OPCODE_RST;
            en_opcode_reg    <= mwem_pkg::EN_OPCODE_RST;
            dis_opcode_reg   <= mwem_pkg::DIS_OPCODE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mwem_pkg::REG_HALF_PERIOD:  half_period_reg  <= cfg_wdata[7:0];
                mwem_pkg::REG_SAMPLE_DELAY: sample_delay_reg <= cfg_wdata[7:0];
                mwem_pkg::REG_WRITE_WAIT:   write_wait_reg   <= cfg_wdata;
                mwem_pkg::REG_POLL_READY:   poll_ready_reg   <= cfg_wdata[0];
                mwem_pkg::REG_READ_OPCODE:  read_opcode_reg  <= cfg_wdata[7:0];
                mwem_pkg::REG_EN_OPCODE:    en_opcode_reg    <= cfg_wdata[7:0];
                mwem_pkg::REG_DIS_OPCODE:   dis_opcode_reg   <= cfg_wdata[7:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tick sequencer state
    // ------------------------------------------------------------------
    logic [3:0]           phase_reg,    phase_next;
    logic [BCNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [15:0]          wait_count_reg, wait_count_next;
    logic [SEND_W-1:0]    send_shift_reg, send_shift_next;
    logic [DATA_BITS-1:0] recv_shift_reg, recv_shift_next;
    logic [2:0]           pend_act_reg,  pend_act_next;

    logic                 s_fire;
    logic                 launch;
    logic [3:0]           cur_phase;
    logic [7:0]           half;
    logic [7:0]           samp;
    logic [15:0]          wait_inc;
    logic [BCNT_W-1:0]    bc_dec;
    logic [BIDX_W-1:0]    bit_idx;
    logic [7:0]           instr_src;
    logic [INSTR_BITS:0]  instr_frame;

    // result of this tick
    logic                 r_cs, r_sk, r_so, r_busy, r_done;

    assign s_fire = s_valid && s_ready;

    // A command only starts from idle; codes above disable are plain ticks.
    assign launch = (phase_reg == mwem_pkg::PH_IDLE)
                 && (s_action >= mwem_pkg::ACT_WRITE)
                 && (s_action <= mwem_pkg::ACT_DISABLE);
    assign cur_phase = launch ? mwem_pkg::PH_SETUP : phase_reg;

    // zero timing registers count as one tick
    assign half = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign samp = (sample_delay_reg == 8'd0) ? 8'd1 : sample_delay_reg;

    assign wait_inc = wait_count_reg + 16'd1;
    assign bc_dec   = (bit_count_reg != '0) ? bit_count_reg - BCNT_W'(1) : bit_count_reg;
    assign bit_idx  = BIDX_W'(bit_count_reg - BCNT_W'(1));

    always_comb begin
        priority case (s_action)
            mwem_pkg::ACT_WRITE:  instr_src = s_write_opcode | s_address;
            mwem_pkg::ACT_READ:   instr_src = read_opcode_reg | s_address;
            mwem_pkg::ACT_ENABLE: instr_src = en_opcode_reg;
            default:              instr_src = dis_opcode_reg;
        endcase
    end

    // start bit above the instruction
    assign instr_frame = {1'b1, INSTR_BITS'(instr_src)};

    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        wait_count_next = wait_count_reg;
        send_shift_next = send_shift_reg;
        recv_shift_next = recv_shift_reg;
        pend_act_next   = pend_act_reg;
        r_cs   = 1'b0;
        r_sk   = 1'b0;
        r_so   = 1'b0;
        r_done = 1'b0;
        r_busy = (cur_phase != mwem_pkg::PH_IDLE);

        if (launch) begin
            if (s_action == mwem_pkg::ACT_WRITE) begin
                send_shift_next = {instr_frame, s_write_data};
                bit_count_next  = BCNT_W'(SEND_W);
            end else begin
                send_shift_next = SEND_W'(instr_frame);
                bit_count_next  = BCNT_W'(INSTR_BITS + 1);
            end
            if (s_action == mwem_pkg::ACT_READ) begin
                recv_shift_next = '0;
            end
            pend_act_next   = s_action;
            wait_count_next = '0;
        end

        unique case (cur_phase)
            mwem_pkg::PH_IDLE: ;
            mwem_pkg::PH_SETUP: begin
                r_cs            = 1'b1;
                wait_count_next = '0;
                phase_next      = mwem_pkg::PH_SEND_LOW;
            end
            mwem_pkg::PH_SEND_LOW, mwem_pkg::PH_SEND_HIGH: begin
                r_cs = 1'b1;
                r_sk = (cur_phase == mwem_pkg::PH_SEND_HIGH);
                r_so = (bit_count_reg != '0) ? send_shift_reg[bit_idx] : 1'b0;
                wait_count_next = wait_inc;
                if (wait_inc >= {8'd0, half}) begin
                    wait_count_next = '0;
                    if (cur_phase == mwem_pkg::PH_SEND_LOW) begin
                        phase_next = mwem_pkg::PH_SEND_HIGH;
                    end else begin
                        bit_count_next = bc_dec;
                        if (bc_dec == '0) begin
                            if (pend_act_reg == mwem_pkg::ACT_READ) begin
                                bit_count_next = BCNT_W'(DATA_BITS);
                                phase_next     = mwem_pkg::PH_RECV_LOW;
                            end else begin
                                phase_next = mwem_pkg::PH_HOLD;
                            end
                        end else begin
                            phase_next = mwem_pkg::PH_SEND_LOW;
                        end
                    end
                end
            end
            mwem_pkg::PH_RECV_LOW: begin
                r_cs            = 1'b1;
                wait_count_next = wait_inc;
                if (wait_inc >= {8'd0, half}) begin
                    wait_count_next = '0;
                    phase_next      = mwem_pkg::PH_RECV_HIGH;
                end
            end
            mwem_pkg::PH_RECV_HIGH: begin
                r_cs            = 1'b1;
                r_sk            = 1'b1;
                wait_count_next = wait_inc;
                // sample on the last high tick
                if (wait_inc >= {8'd0, samp}) begin
                    wait_count_next = '0;
                    recv_shift_next = {recv_shift_reg[DATA_BITS-2:0], s_serial_in};
                    bit_count_next  = bc_dec;
                    if (bc_dec == '0) begin
                        r_done     = 1'b1;
                        phase_next = mwem_pkg::PH_HOLD;
                    end else begin
                        phase_next = mwem_pkg::PH_RECV_LOW;
                    end
                end
            end
            mwem_pkg::PH_HOLD: begin
                // chip select low for one tick, then pick the write recovery
                wait_count_next = '0;
                if (pend_act_reg != mwem_pkg::ACT_WRITE) begin
                    phase_next = mwem_pkg::PH_IDLE;
                end else if (poll_ready_reg) begin
                    phase_next = mwem_pkg::PH_POLL;
                end else if (write_wait_reg == 16'd0) begin
                    phase_next = mwem_pkg::PH_IDLE;
                end else begin
                    phase_next = mwem_pkg::PH_WAIT;
                end
            end
            mwem_pkg::PH_WAIT: begin
                wait_count_next = wait_inc;
                if (wait_inc >= write_wait_reg) begin
                    wait_count_next = '0;
                    phase_next      = mwem_pkg::PH_IDLE;
                end
            end
            mwem_pkg::PH_POLL: begin
                // first poll tick only raises chip select
                r_cs = 1'b1;
                if (wait_count_reg == 16'd0) begin
                    wait_count_next = 16'd1;
                end else if (s_serial_in) begin
                    wait_count_next = '0;
                    phase_next      = mwem_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = mwem_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= mwem_pkg::PH_IDLE;
            bit_count_reg  <= '0;
            wait_count_reg <= '0;
            send_shift_reg <= '0;
            recv_shift_reg <= '0;
            pend_act_reg   <= mwem_pkg::ACT_NONE;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            wait_count_reg <= wait_count_next;
            send_shift_reg <= send_shift_next;
            recv_shift_reg <= recv_shift_next;
            pend_act_reg   <= pend_act_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer: output register plus skid register
    // ------------------------------------------------------------------
    logic [RES_W-1:0] res_new;
    logic [RES_W-1:0] out_data_reg;
    logic [RES_W-1:0] skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             m_fire;

    assign res_new = {r_cs, r_sk, r_so, r_busy, recv_shift_next, r_done};
    assign m_fire  = out_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_fire) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else if (!s_fire) begin
                out_valid_reg <= 1'b0;
            end
        end else if (s_fire) begin
            if (!out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_fire) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_fire) begin
                out_data_reg <= res_new;
            end
        end else if (s_fire) begin
            if (!out_valid_reg) begin
                out_data_reg <= res_new;
            end else begin
                skid_data_reg <= res_new;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_chip_select  = out_data_reg[RES_W-1];
    assign m_serial_clock = out_data_reg[RES_W-2];
    assign m_serial_out   = out_data_reg[RES_W-3];
    assign m_busy_res     = out_data_reg[RES_W-4];
    assign m_read_word    = out_data_reg[DATA_BITS:1];
    assign m_read_done    = out_data_reg[0];

endmodule

// File: test/tb_microwire_eeprom_master_core.sv
`timescale 1ns / 1ps

module tb_microwire_eeprom_master_core;

    localparam int DW       = mwem_pkg::DATA_BITS_DEF;
    localparam int IW       = mwem_pkg::INSTR_BITS_DEF;
    localparam int WR_BITS  = 1 + IW + DW;   // start bit + instruction + data word
    localparam int CMD_BITS = 1 + IW;        // start bit + instruction

    // Action codes above ACT_DISABLE carry no command; the block treats them as ticks.
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]    action;
        logic [7:0]    address;
        logic [7:0]    wopc;
        logic [DW-1:0] wdata;
        logic          sin;
    } tick_t;

    typedef struct packed {
        logic          cs;
        logic          sk;
        logic          so;
        logic          busy;
        logic [DW-1:0] word;
        logic          done;
    } pins_t;

    // ---------------------------------------------------------------- DUT ports
    logic          aclk           = 1'b0;
    logic          aresetn        = 1'b0;
    logic          cfg_we         = 1'b0;
    logic [2:0]    cfg_index      = mwem_pkg::REG_HALF_PERIOD;
    logic [15:0]   cfg_wdata      = '0;
    logic          s_valid        = 1'b0;
    logic          s_ready;
    logic [2:0]    s_action       = mwem_pkg::ACT_NONE;
    logic [7:0]    s_address      = '0;
    logic [7:0]    s_write_opcode = '0;
    logic [DW-1:0] s_write_data   = '0;
    logic          s_serial_in    = 1'b0;
    logic          m_valid;
    logic          m_ready        = 1'b0;
    logic          m_chip_select;
    logic          m_serial_clock;
    logic          m_serial_out;
    logic          m_busy_res;
    logic [DW-1:0] m_read_word;
    logic          m_read_done;

    microwire_eeprom_master_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_address      (s_address),
        .s_write_opcode (s_write_opcode),
        .s_write_data   (s_write_data),
        .s_serial_in    (s_serial_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chip_select  (m_chip_select),
        .m_serial_clock (m_serial_clock),
        .m_serial_out   (m_serial_out),
        .m_busy_res     (m_busy_res),
        .m_read_word    (m_read_word),
        .m_read_done    (m_read_done)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------- predictor state
    // Shadow copy of the registers, written together with the DUT's.
    logic [7:0]  cfg_half   = mwem_pkg::HALF_PERIOD_RST;
    logic [7:0]  cfg_dly    = mwem_pkg::SAMPLE_DELAY_RST;
    logic [15:0] cfg_wait   = mwem_pkg::WRITE_WAIT_RST;
    logic        cfg_poll   = mwem_pkg::POLL_READY_RST;
    logic [7:0]  cfg_rd_op  = mwem_pkg::READ_OPCODE_RST;
    logic [7:0]  cfg_en_op  = mwem_pkg::EN_OPCODE_RST;
    logic [7:0]  cfg_dis_op = mwem_pkg::DIS_OPCODE_RST;

    // Shadow sequencer.
    logic [3:0]         seq_phase = mwem_pkg::PH_IDLE;
    logic [4:0]         bits_left = '0;
    logic [15:0]        tick_cnt  = '0;
    logic [WR_BITS-1:0] tx_shift  = '0;
    logic [DW-1:0]      rx_word   = '0;
    logic [2:0]         cmd_held  = mwem_pkg::ACT_NONE;

    // ------------------------------------------------------- bookkeeping
    tick_t ticks_to_send[$];   // items waiting for the driver
    pins_t pins_due[$];        // predicted pin levels, oldest first
    tick_t offered;            // item currently on the input port
    int    issued     = 0;
    int    accepted   = 0;
    int    mismatches = 0;
    int    gap_left   = 0;
    int    stall_left = 0;
    bit    calm       = 1'b0;  // no idling on either side in the final stretch
    bit    long_stall_done = 1'b0;

    logic [2:0] cmd_codes[4] = '{mwem_pkg::ACT_WRITE, mwem_pkg::ACT_READ,
                                 mwem_pkg::ACT_ENABLE, mwem_pkg::ACT_DISABLE};

    // One base tick of the serial master: returns the pin levels for this tick
    // and moves the shadow sequencer on.
    function automatic pins_t predict_pins(input tick_t t);
        pins_t        p;
        logic [IW:0]  instr;
        logic [7:0]   half;
        logic [7:0]   dly;
        p    = '0;
        half = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
        dly  = (cfg_dly == 8'd0) ? 8'd1 : cfg_dly;

        // A command only starts from idle; while busy it is just a tick.
        if (seq_phase == mwem_pkg::PH_IDLE && t.action >= mwem_pkg::ACT_WRITE &&
            t.action <= mwem_pkg::ACT_DISABLE) begin
            case (t.action)
                mwem_pkg::ACT_WRITE:  instr = {1'b1, t.wopc | t.address};
                mwem_pkg::ACT_READ:   instr = {1'b1, cfg_rd_op | t.address};
                mwem_pkg::ACT_ENABLE: instr = {1'b1, cfg_en_op};
                default:              instr = {1'b1, cfg_dis_op};
            endcase
            if (t.action == mwem_pkg::ACT_WRITE) begin
                tx_shift  = {instr, t.wdata};
                bits_left = 5'(WR_BITS);
            end else begin
                tx_shift  = WR_BITS'(instr);
                bits_left = 5'(CMD_BITS);
            end
            if (t.action == mwem_pkg::ACT_READ)
                rx_word = '0;
            cmd_held  = t.action;
            tick_cnt  = '0;
            seq_phase = mwem_pkg::PH_SETUP;
        end

        p.busy = (seq_phase != mwem_pkg::PH_IDLE);

        case (seq_phase)
            mwem_pkg::PH_SETUP: begin
                p.cs      = 1'b1;
                tick_cnt  = '0;
                seq_phase = mwem_pkg::PH_SEND_LOW;
            end
            mwem_pkg::PH_SEND_LOW, mwem_pkg::PH_SEND_HIGH: begin
                p.cs = 1'b1;
                p.sk = (seq_phase == mwem_pkg::PH_SEND_HIGH);
                p.so = (bits_left != 5'd0) ? tx_shift[bits_left - 5'd1] : 1'b0;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= half) begin
                    tick_cnt = '0;
                    if (seq_phase == mwem_pkg::PH_SEND_LOW) begin
                        seq_phase = mwem_pkg::PH_SEND_HIGH;
                    end else begin
                        if (bits_left != 5'd0)
                            bits_left = bits_left - 5'd1;
                        if (bits_left != 5'd0) begin
                            seq_phase = mwem_pkg::PH_SEND_LOW;
                        end else if (cmd_held == mwem_pkg::ACT_READ) begin
                            bits_left = 5'(DW);
                            seq_phase = mwem_pkg::PH_RECV_LOW;
                        end else begin
                            seq_phase = mwem_pkg::PH_HOLD;
                        end
                    end
                end
            end
            mwem_pkg::PH_RECV_LOW: begin
                p.cs = 1'b1;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= half) begin
                    tick_cnt  = '0;
                    seq_phase = mwem_pkg::PH_RECV_HIGH;
                end
            end
            mwem_pkg::PH_RECV_HIGH: begin
                p.cs = 1'b1;
                p.sk = 1'b1;
                tick_cnt = tick_cnt + 16'd1;
                // sample on the last high tick
                if (tick_cnt >= dly) begin
                    tick_cnt = '0;
                    rx_word  = {rx_word[DW-2:0], t.sin};
                    if (bits_left != 5'd0)
                        bits_left = bits_left - 5'd1;
                    if (bits_left == 5'd0) begin
                        p.done    = 1'b1;
                        seq_phase = mwem_pkg::PH_HOLD;
                    end else begin
                        seq_phase = mwem_pkg::PH_RECV_LOW;
                    end
                end
            end
            mwem_pkg::PH_HOLD: begin
                // chip select low for one tick, then write recovery if needed
                tick_cnt = '0;
                if (cmd_held != mwem_pkg::ACT_WRITE)
                    seq_phase = mwem_pkg::PH_IDLE;
                else if (cfg_poll)
                    seq_phase = mwem_pkg::PH_POLL;
                else
                    seq_phase = (cfg_wait == 16'd0) ? mwem_pkg::PH_IDLE : mwem_pkg::PH_WAIT;
            end
            mwem_pkg::PH_WAIT: begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= cfg_wait) begin
                    tick_cnt  = '0;
                    seq_phase = mwem_pkg::PH_IDLE;
                end
            end
            mwem_pkg::PH_POLL: begin
                // first poll tick only raises chip select; ready is looked at after
                p.cs = 1'b1;
                if (tick_cnt == 16'd0) begin
                    tick_cnt = 16'd1;
                end else if (t.sin) begin
                    tick_cnt  = '0;
                    seq_phase = mwem_pkg::PH_IDLE;
                end
            end
            default: seq_phase = mwem_pkg::PH_IDLE;
        endcase

        p.word = rx_word;
        return p;
    endfunction

    // Ticks a command keeps the sequencer busy, counting the command's own tick.
    // Poll length is a guess since it depends on serial_in.
    function automatic int frame_ticks(input logic [2:0] act);
        int half;
        int dly;
        int n;
        half = (cfg_half == 8'd0) ? 1 : int'(cfg_half);
        dly  = (cfg_dly == 8'd0) ? 1 : int'(cfg_dly);
        n = 2 + ((act == mwem_pkg::ACT_WRITE) ? WR_BITS : CMD_BITS) * 2 * half;
        if (act == mwem_pkg::ACT_READ)
            n += DW * (half + dly);
        if (act == mwem_pkg::ACT_WRITE)
            n += cfg_poll ? 3 : int'(cfg_wait);
        return n;
    endfunction

    // -------------------------------------------------------------- driver
    // Valid never waits for ready; payload holds until the handshake.
    always @(posedge aclk) begin : driver
        logic took;
        took = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (took) begin
                pins_due.push_back(predict_pins(offered));
                accepted++;
            end
            if (!s_valid || took) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 7);   // random idle gap before the next item
                    s_valid <= 1'b0;
                end else if (ticks_to_send.size() != 0) begin
                    offered = ticks_to_send.pop_front();
                    s_valid        <= 1'b1;
                    s_action       <= offered.action;
                    s_address      <= offered.address;
                    s_write_opcode <= offered.wopc;
                    s_write_data   <= offered.wdata;
                    s_serial_in    <= offered.sin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------ receiver
    // Random short stalls, plus one long hold while plenty of items are queued
    // so the output buffer fills and s_ready drops.
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!long_stall_done && ticks_to_send.size() > 100) begin
            long_stall_done = 1'b1;
            stall_left      = 63;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------- monitor
    always @(posedge aclk) begin : monitor
        pins_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pins_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected item cs=%b sk=%b so=%b busy=%b word=%h done=%b",
                             $realtime, m_chip_select, m_serial_clock, m_serial_out,
                             m_busy_res, m_read_word, m_read_done);
            end else begin
                want = pins_due.pop_front();
                if (m_chip_select !== want.cs || m_serial_clock !== want.sk ||
                    m_serial_out !== want.so || m_busy_res !== want.busy ||
                    m_read_word !== want.word || m_read_done !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch exp cs=%b sk=%b so=%b busy=%b word=%h done=%b",
                                 $realtime, want.cs, want.sk, want.so, want.busy, want.word,
                                 want.done);
                        $display("%0t:          got cs=%b sk=%b so=%b busy=%b word=%h done=%b",
                                 $realtime, m_chip_select, m_serial_clock, m_serial_out,
                                 m_busy_res, m_read_word, m_read_done);
                    end
                end
            end
        end
    end

    // ----------------------------------------------------- stimulus helpers
    task automatic queue_tick(input tick_t t);
        ticks_to_send.push_back(t);
        issued++;
    endtask

    // Plain tick with random pin data; never starts a command.
    function automatic tick_t filler();
        tick_t t;
        t = tick_t'({$urandom, $urandom});
        t.action = ($urandom_range(0, 3) == 0) ?
                   3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)) : mwem_pkg::ACT_NONE;
        return t;
    endfunction

    function automatic tick_t command(input logic [2:0] act, input logic [7:0] addr,
                                      input logic [7:0] opc, input logic [DW-1:0] data);
        tick_t t;
        t         = filler();
        t.action  = act;
        t.address = addr;
        t.wopc    = opc;
        t.wdata   = data;
        return t;
    endfunction

    // Every queued item accepted and every predicted item seen.
    task automatic wait_drained();
        @(posedge aclk);
        while (accepted != issued || pins_due.size() != 0)
            @(posedge aclk);
    endtask

    // Sender pause: run plain ticks until the sequencer is back in idle.
    task automatic settle();
        wait_drained();
        while (seq_phase != mwem_pkg::PH_IDLE) begin
            for (int i = 0; i < 32; i++)
                queue_tick(filler());
            wait_drained();
        end
    endtask

    task automatic run_command(input logic [2:0] act, input logic [7:0] addr,
                               input logic [7:0] opc, input logic [DW-1:0] data);
        queue_tick(command(act, addr, opc, data));
        settle();
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            mwem_pkg::REG_HALF_PERIOD:  cfg_half   = val[7:0];
            mwem_pkg::REG_SAMPLE_DELAY: cfg_dly    = val[7:0];
            mwem_pkg::REG_WRITE_WAIT:   cfg_wait   = val;
            mwem_pkg::REG_POLL_READY:   cfg_poll   = val[0];
            mwem_pkg::REG_READ_OPCODE:  cfg_rd_op  = val[7:0];
            mwem_pkg::REG_EN_OPCODE:    cfg_en_op  = val[7:0];
            mwem_pkg::REG_DIS_OPCODE:   cfg_dis_op = val[7:0];
            default: ;
        endcase
    endtask

    // Reprogram all registers with the sequencer idle.
    task automatic configure(input logic [7:0] half, input logic [7:0] dly,
                             input logic [15:0] wr_wait, input logic poll,
                             input logic [7:0] rd_op, input logic [7:0] en_op,
                             input logic [7:0] dis_op);
        settle();
        cfg_write(mwem_pkg::REG_HALF_PERIOD, {8'd0, half});
        cfg_write(mwem_pkg::REG_SAMPLE_DELAY, {8'd0, dly});
        cfg_write(mwem_pkg::REG_WRITE_WAIT, wr_wait);
        cfg_write(mwem_pkg::REG_POLL_READY, {15'd0, poll});
        cfg_write(mwem_pkg::REG_READ_OPCODE, {8'd0, rd_op});
        cfg_write(mwem_pkg::REG_EN_OPCODE, {8'd0, en_op});
        cfg_write(mwem_pkg::REG_DIS_OPCODE, {8'd0, dis_op});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly complete command frames with random content; the rest is noise and
    // frames cut short so that the next command lands while the block is busy.
    task automatic random_phase(input int n);
        int         sent;
        int         len;
        tick_t      t;
        logic [2:0] act;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 8) begin
                act = cmd_codes[$urandom_range(0, 3)];
                queue_tick(command(act, 8'($urandom), 8'($urandom), DW'($urandom)));
                len = frame_ticks(act) - 1;
                if ($urandom_range(0, 7) == 0)
                    len -= int'($urandom_range(1, 4));
                else
                    len += int'($urandom_range(0, 3));
                for (int i = 0; i < len; i++)
                    queue_tick(filler());
                sent += len + 1;
            end else begin
                len = int'($urandom_range(1, 6));
                for (int i = 0; i < len; i++) begin
                    t = tick_t'({$urandom, $urandom});
                    t.action = 3'($urandom_range(0, 7));
                    queue_tick(t);
                end
                sent += len;
            end
        end
    endtask

    // ---------------------------------------------------------------- main
    initial begin : main
        tick_t t;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings first, plain ticks incl. the spare action codes.
        for (int i = 0; i < 3; i++)
            queue_tick(filler());
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
            t = filler();
            t.action = 3'(a);
            queue_tick(t);
        end
        run_command(mwem_pkg::ACT_ENABLE, 8'h00, 8'h00, 16'h0000);
        run_command(mwem_pkg::ACT_DISABLE, 8'hFF, 8'hFF, 16'hFFFF);
        run_command(mwem_pkg::ACT_READ, 8'h00, 8'h00, 16'h0000);

        // Command while busy is dropped.
        queue_tick(command(mwem_pkg::ACT_READ, 8'h55, 8'h00, 16'h0000));
        for (int i = 0; i < 3; i++)
            queue_tick(filler());
        queue_tick(command(mwem_pkg::ACT_WRITE, 8'hFF, 8'hFF, 16'h1234));
        settle();

        // Zero half period / sample delay count as one tick; zero write wait.
        configure(8'd0, 8'd0, 16'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF);
        run_command(mwem_pkg::ACT_WRITE, 8'hFF, 8'hFF, 16'h0000);
        run_command(mwem_pkg::ACT_READ, 8'hFF, 8'h00, 16'h0000);
        run_command(mwem_pkg::ACT_ENABLE, 8'h00, 8'h00, 16'h0000);
        run_command(mwem_pkg::ACT_DISABLE, 8'h00, 8'h00, 16'h0000);

        // Ready polling after a write, all-zero opcodes.
        configure(8'd1, 8'd1, 16'd0, 1'b1, 8'h00, 8'h00, 8'h00);
        run_command(mwem_pkg::ACT_WRITE, 8'h00, 8'h00, 16'hA5A5);
        run_command(mwem_pkg::ACT_READ, 8'h00, 8'hFF, 16'hFFFF);
        run_command(mwem_pkg::ACT_ENABLE, 8'hFF, 8'hFF, 16'hFFFF);

        // Slower serial clock, sample point late in the high phase.
        configure(8'd3, 8'd6, 16'd16, 1'b0, 8'h80, 8'h30, 8'h00);
        run_command(mwem_pkg::ACT_READ, 8'h2A, 8'h00, 16'h0000);

        // Random part, several settings.
        configure(8'd1, 8'd1, 16'd3, 1'b0, 8'h80, 8'h30, 8'h00);
        random_phase(200);
        configure(8'd2, 8'd3, 16'd0, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(150);
        configure(8'd0, 8'd0, 16'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF);
        random_phase(150);
        configure(8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
                  16'($urandom_range(0, 20)), 1'($urandom_range(0, 1)),
                  8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(150);

        // Final stretch at full rate on both sides.
        configure(8'd1, 8'd2, 16'd1, 1'($urandom_range(0, 1)),
                  8'($urandom), 8'($urandom), 8'($urandom));
        calm = 1'b1;
        random_phase(150);

        wait_drained();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pins_due.size() == 0) begin
            $display("microwire_eeprom_master_core verification clean");
        end else begin
            $display("microwire_eeprom_master_core verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin : watchdog
        #24000000;
        $display("microwire_eeprom_master_core verification failed");
        $finish;
    end

endmodule
